/* design/multichannel_block_average_gate_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel block average gate
// Clocked assertion helpers used by mbag_state.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BLOCK_AVERAGE_GATE_DEFINES_SVH
`define MULTICHANNEL_BLOCK_AVERAGE_GATE_DEFINES_SVH

// Implication checked at every rising aclk edge, off while reset is low.
`define MBAG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same check, also active during reset.
`define MBAG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* design/mbag_pkg.sv */
// ----------------------------------------------------------------------------
// mbag_pkg
// Constants, result type and arithmetic helpers of the block average gate.
// ----------------------------------------------------------------------------
package mbag_pkg;

    localparam int CHANNELS   = 8;
    localparam int SAMPLES    = 8;
    localparam int CH_W       = 3;
    localparam int CNT_W      = 4;
    localparam int LIM_W      = 15;
    localparam int DATA_W     = 16;
    localparam int RND_W      = $clog2(SAMPLES) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_LIMIT    = 2'd1;

    localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;
    localparam logic [LIM_W-1:0] LIM_RESET = 15'd2;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] average;
        logic              accepted;
        logic [DATA_W-1:0] held_value;
        logic              round_done;
    } result_t;

    // Signed block average, truncated toward zero.
    function automatic logic [DATA_W-1:0] block_average(input logic [DATA_W-1:0] sum);
        logic signed [31:0] q;
        q = $signed(sum) / SAMPLES;
        return q[DATA_W-1:0];
    endfunction

    // Magnitude of the wrapped 16-bit difference against the limit.
    function automatic logic gate_pass(input logic [DATA_W-1:0] avg,
                                       input logic [DATA_W-1:0] prev,
                                       input logic [LIM_W-1:0]  limit);
        logic [DATA_W-1:0] d;
        logic [DATA_W:0]   mag;
        d   = avg - prev;
        mag = d[DATA_W-1] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
        return (mag <= {2'b00, limit});
    endfunction

endpackage

/* design/mbag_state.sv */
// ----------------------------------------------------------------------------
// mbag_state
// Per-channel sums, averages and round position; one sample per cycle while advance is high.
// ----------------------------------------------------------------------------
`include "multichannel_block_average_gate_defines.svh"

module mbag_state
    import mbag_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [DATA_W-1:0] sample,
    input  logic [CNT_W-1:0]  channel_count,
    input  logic [LIM_W-1:0]  diff_limit,
    output logic              produce,
    output result_t           result
);

    logic [DATA_W-1:0] channel_sum_reg      [CHANNELS];
    logic [DATA_W-1:0] previous_average_reg [CHANNELS];
    logic [DATA_W-1:0] held_average_reg     [CHANNELS];
    logic [RND_W-1:0]  round_index_reg;
    logic [CH_W-1:0]   channel_index_reg;

    logic [CNT_W-1:0]  count_eff;
    logic [CH_W-1:0]   ch;
    logic [RND_W-1:0]  rnd;
    logic              last_round;
    logic              last_channel;
    logic [DATA_W-1:0] sum_new;
    logic [DATA_W-1:0] avg;
    logic              ok;
    logic [DATA_W-1:0] held_new;
    logic [RND_W-1:0]  round_index_next;
    logic [CH_W-1:0]   channel_index_next;

    always_comb begin
        count_eff = channel_count;
        if (count_eff == '0) begin
            count_eff = CNT_W'(1);
        end
        if (count_eff > CNT_W'(CHANNELS)) begin
            count_eff = CNT_W'(CHANNELS);
        end

        // Count lowered mid round: restart at channel 0.
        ch  = ({1'b0, channel_index_reg} >= count_eff) ? '0 : channel_index_reg;
        rnd = (round_index_reg >= RND_W'(SAMPLES)) ? '0 : round_index_reg;

        last_round   = (({1'b0, rnd} + 1'b1) >= (RND_W + 1)'(SAMPLES));
        last_channel = (({1'b0, ch} + CNT_W'(1)) >= count_eff);

        sum_new  = channel_sum_reg[ch] + sample;
        avg      = block_average(sum_new);
        ok       = gate_pass(avg, previous_average_reg[ch], diff_limit);
        held_new = ok ? avg : held_average_reg[ch];

        if (last_channel) begin
            channel_index_next = '0;
            round_index_next   = last_round ? '0 : rnd + 1'b1;
        end else begin
            channel_index_next = ch + 1'b1;
            round_index_next   = rnd;
        end

        produce           = last_round;
        result.channel    = ch;
        result.average    = avg;
        result.accepted   = ok;
        result.held_value = held_new;
        result.round_done = last_channel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                channel_sum_reg[i]      <= '0;
                previous_average_reg[i] <= '0;
                held_average_reg[i]     <= '0;
            end
            round_index_reg   <= '0;
            channel_index_reg <= '0;
        end else if (advance) begin
            round_index_reg   <= round_index_next;
            channel_index_reg <= channel_index_next;
            if (last_round) begin
                // Close the block: restart the sum, latch the averages.
                channel_sum_reg[ch]      <= '0;
                previous_average_reg[ch] <= avg;
                held_average_reg[ch]     <= held_new;
            end else begin
                channel_sum_reg[ch] <= sum_new;
            end
        end
    end

    `MBAG_ASSERT(a_wrap_channel, advance && last_channel |=> channel_index_reg == '0, "channel index did not wrap")
    `MBAG_ASSERT(a_sum_cleared, advance && last_round |=> channel_sum_reg[$past(ch)] == '0, "block sum not restarted")
    `MBAG_ASSERT(a_held_on_accept, produce && result.accepted |-> result.held_value == result.average, "accepted average not held")
    `MBAG_ASSERT(a_round_range, round_index_reg < RND_W'(SAMPLES), "round index out of range")

endmodule

/* design/mbag_result_reg.sv */
// ----------------------------------------------------------------------------
// mbag_result_reg
// Output register of the result channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module mbag_result_reg
    import mbag_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_word,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

/* design/multichannel_block_average_gate.sv */
// ----------------------------------------------------------------------------
// multichannel_block_average_gate
// Per-channel block averaging of temperature samples with a stability gate.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed sample word per handshake, channels in round order
//   (0 .. channel_count-1). After SAMPLES rounds each sample of the last round
//   yields one result word on m_*: channel, block average, gate decision,
//   held value and a round_done flag on the round's last channel. Samples of
//   earlier rounds yield no result.
//   cfg_* writes channel_count (index 0) and diff_limit (index 1); cfg_ready
//   is always high. Write only while the block is idle.
//   A sample accepted on s_* is held in the input register, then its
//   per-channel update is registered into the output register. One sample
//   is taken per cycle unless a result is held back (see below), set by the
//   read-modify-write of the per-channel sum.
//   Reset clears all sums, averages, held values and the round position, and
//   loads channel_count = 8, diff_limit = 2.
//   While m_ready is low with a result waiting, a sample that would produce
//   a result holds in the input register and s_ready drops; samples that
//   produce none keep flowing.
// ----------------------------------------------------------------------------
module multichannel_block_average_gate
    import mbag_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_sample,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_channel,
    output logic [DATA_W-1:0]     m_average,
    output logic                  m_accepted,
    output logic [DATA_W-1:0]     m_held_value,
    output logic                  m_round_done,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0]  channel_count_reg;
    logic [LIM_W-1:0]  diff_limit_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [DATA_W-1:0] sample_reg;
    logic              s_fire;
    logic              advance;
    logic              produce;
    logic              out_free;
    result_t           result;
    result_t           m_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CNT_RESET;
            diff_limit_reg    <= LIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                REG_DIFF_LIMIT:    diff_limit_reg    <= cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the sample only when its result has no room.
    assign advance = in_valid_reg && (!produce || out_free);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_sample;
        end
    end

    mbag_state u_state (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .sample        (sample_reg),
        .channel_count (channel_count_reg),
        .diff_limit    (diff_limit_reg),
        .produce       (produce),
        .result        (result)
    );

    mbag_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && produce),
        .load_word (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    assign m_channel    = m_word.channel;
    assign m_average    = m_word.average;
    assign m_accepted   = m_word.accepted;
    assign m_held_value = m_word.held_value;
    assign m_round_done = m_word.round_done;

endmodule
